// ===== sv/bts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants and functions of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int MAX_TEX_WIDTH_DEF  = 256;
   localparam int MAX_TEX_HEIGHT_DEF = 256;
   localparam int ADDR_W   = 16;
   localparam int TEXEL_W  = 24;
   localparam int CFG_W    = 16;
   localparam int CFG_IDX_W = 3;

   localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_S_EDGE     = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_T_EDGE     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_TEX_ON     = 3'd4;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [7:0] GRAY_LEVEL = 8'd222;
   localparam logic [7:0] ALPHA_ONE  = 8'd255;
   localparam logic [15:0] HALF_Q8   = 16'd128;

   // Filter mode of one sample.
   localparam logic [1:0] MODE_NEAR = 2'd0;
   localparam logic [1:0] MODE_LINT = 2'd1;
   localparam logic [1:0] MODE_LINS = 2'd2;
   localparam logic [1:0] MODE_BILI = 2'd3;

   // Clamp a Q2.16 coordinate to 0..65536.
   function automatic logic [16:0] clamp_coord(input logic [17:0] raw);
      logic [16:0] c;
      begin
         if (raw[17]) c = 17'd0;
         else if (raw[16:0] > 17'd65536) c = 17'd65536;
         else c = raw[16:0];
         return c;
      end
   endfunction

   // Two-tap blend with a 9-bit weight (0..256) on the upper texel, rounded half up.
   function automatic logic [7:0] lerp8(input logic [7:0] hi, input logic [7:0] lo,
                                        input logic [8:0] w);
      logic [17:0] s;
      begin
         s = 18'(hi) * 18'(w) + 18'(lo) * (18'd256 - 18'(w)) + 18'd128;
         return s[15:8];
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Texel store with a four-bank bilinear fetch and blend pipeline.
// ----------------------------------------------------------------------------
// One word per clock in while req_tready is high. Write words load a texel
// into four bank copies of the 64K x 24 store; sample words clamp and scale
// s and t, read the four neighbor texels from the four copies in the same
// cycle, blend along s (stage 3) and along t (stage 4), then wait in an
// eight-word result FIFO. The request side stalls only when eight samples are
// in flight or waiting in that FIFO. A write updates the banks in the stage
// where a later sample reads them, so every sample sees all earlier writes
// without forwarding or stalls.
module bilinear_texture_sampler #(
   parameter int MAX_TEX_WIDTH  = bts_pkg::MAX_TEX_WIDTH_DEF,
   parameter int MAX_TEX_HEIGHT = bts_pkg::MAX_TEX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // texel_index[15:0], red[23:16], green[31:24], blue[39:32],
   // coord_s[57:40], coord_t[75:58], zero pad to 80
   input  wire logic [79:0] req_tdata,
   input  wire logic        req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic [31:0]      rsp_tdata
);
   localparam int WB = $clog2(MAX_TEX_WIDTH + 1);
   localparam int HB = $clog2(MAX_TEX_HEIGHT + 1);

   // configuration
   logic [8:0]  width_ff, height_ff;
   logic [15:0] s_lim_ff, t_lim_ff;
   logic        tex_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256; height_ff <= 9'd256;
         s_lim_ff <= 16'hFFFF; t_lim_ff <= 16'hFFFF; tex_on_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            bts_pkg::REG_TEX_WIDTH:  width_ff  <= csr_wdata[8:0];
            bts_pkg::REG_TEX_HEIGHT: height_ff <= csr_wdata[8:0];
            bts_pkg::REG_S_EDGE:     s_lim_ff  <= csr_wdata;
            bts_pkg::REG_T_EDGE:     t_lim_ff  <= csr_wdata;
            bts_pkg::REG_TEX_ON:     tex_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [WB-1:0] w_eff;
   logic [HB-1:0] h_eff;
   always_comb begin
      if (width_ff == 9'd0) w_eff = WB'(1);
      else if (32'(width_ff) > MAX_TEX_WIDTH) w_eff = WB'(MAX_TEX_WIDTH);
      else w_eff = WB'(width_ff);
      if (height_ff == 9'd0) h_eff = HB'(1);
      else if (32'(height_ff) > MAX_TEX_HEIGHT) h_eff = HB'(MAX_TEX_HEIGHT);
      else h_eff = HB'(height_ff);
   end

   logic       in_acc;
   logic       out_acc;
   assign in_acc     = req_tvalid && req_tready;
   assign out_acc    = rsp_tvalid && rsp_tready;

   // stage 1: clamp and scale
   logic        v1_ff, smp1_ff, on1_ff;
   logic [15:0] wa1_ff;
   logic [23:0] wd1_ff;
   logic [16:0] cs, ct;
   logic [31:0] xs_in, ys_in;
   logic [31:0] xs1_ff, ys1_ff;
   assign cs = bts_pkg::clamp_coord(req_tdata[57:40]);
   assign ct = bts_pkg::clamp_coord(req_tdata[75:58]);
   assign xs_in = 32'(cs) * 32'(w_eff - WB'(1));
   assign ys_in = 32'(ct) * 32'(h_eff - HB'(1));

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_acc;
      smp1_ff <= req_tuser == bts_pkg::CMD_SAMPLE;
      on1_ff  <= tex_on_ff;
      wa1_ff  <= req_tdata[15:0];
      wd1_ff  <= {req_tdata[39:32], req_tdata[31:24], req_tdata[23:16]};
      xs1_ff  <= xs_in;
      ys1_ff  <= ys_in;
   end

   // stage 1 combinational: addresses and mode
   logic [16:0] x, y, u, v;
   logic        s_off, t_off;
   logic [15:0] nx, ny, xhi, xlo, yhi, ylo;
   logic [8:0]  ws, wt;
   assign x = xs1_ff[24:8];
   assign y = ys1_ff[24:8];
   assign s_off = (x <= 17'(bts_pkg::HALF_Q8)) || (x >= 17'(s_lim_ff));
   assign t_off = (y <= 17'(bts_pkg::HALF_Q8)) || (y >= 17'(t_lim_ff));
   assign u  = x + 17'(bts_pkg::HALF_Q8);
   assign v  = y + 17'(bts_pkg::HALF_Q8);
   assign nx = 16'(u[16:8]);
   assign ny = 16'(v[16:8]);
   assign ws = s_off ? 9'd256 : {1'b0, u[7:0]};
   assign wt = t_off ? 9'd256 : {1'b0, v[7:0]};
   assign xhi = nx;
   assign xlo = s_off ? nx : nx - 16'd1;
   assign yhi = ny;
   assign ylo = t_off ? ny : ny - 16'd1;

   logic [15:0] a00, a01, a10, a11;
   logic [31:0] yhi_m, ylo_m;
   assign yhi_m = 32'(yhi) * 32'(w_eff);
   assign ylo_m = 32'(ylo) * 32'(w_eff);
   assign a11 = 16'(yhi_m) + xhi;
   assign a01 = 16'(yhi_m) + xlo;
   assign a10 = 16'(ylo_m) + xhi;
   assign a00 = 16'(ylo_m) + xlo;

   // four bank copies of the store
   logic [23:0] bank0 [0:65535];
   logic [23:0] bank1 [0:65535];
   logic [23:0] bank2 [0:65535];
   logic [23:0] bank3 [0:65535];
   logic        wr_en;
   logic [23:0] q00_ff, q01_ff, q10_ff, q11_ff;
   assign wr_en = v1_ff && !smp1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank0[wa1_ff] <= wd1_ff; bank1[wa1_ff] <= wd1_ff;
         bank2[wa1_ff] <= wd1_ff; bank3[wa1_ff] <= wd1_ff;
      end
      q00_ff <= bank0[a00]; q01_ff <= bank1[a01];
      q10_ff <= bank2[a10]; q11_ff <= bank3[a11];
   end

   // stage 2: memory data plus weights
   logic       v2_ff, on2_ff;
   logic [8:0] ws2_ff, wt2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff && smp1_ff;
      on2_ff <= on1_ff; ws2_ff <= ws; wt2_ff <= wt;
   end

   // stage 3: blend along s
   logic [7:0] rhi [3], rlo [3];
   logic [7:0] rhi_ff [3], rlo_ff [3];
   logic       v3_ff, on3_ff;
   logic [8:0] wt3_ff;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rhi[c] = bts_pkg::lerp8(q11_ff[8*c +: 8], q01_ff[8*c +: 8], ws2_ff);
         rlo[c] = bts_pkg::lerp8(q10_ff[8*c +: 8], q00_ff[8*c +: 8], ws2_ff);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      on3_ff <= on2_ff; wt3_ff <= wt2_ff;
      rhi_ff <= rhi; rlo_ff <= rlo;
   end

   // Separable rounding differs from one rounding of the full sum, so the
   // bilinear case is recomputed exactly: hold raw texels too.
   logic [23:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [8:0]  ws3_ff;
   always_ff @(posedge clock) begin
      p00_ff <= q00_ff; p01_ff <= q01_ff; p10_ff <= q10_ff; p11_ff <= q11_ff;
      ws3_ff <= ws2_ff;
   end

   // stage 4: blend along t
   logic [7:0]  res [3];
   logic [23:0] col_in;
   logic [17:0] a_hi [3], a_lo [3];
   logic [17:0] a_hi_ff [3], a_lo_ff [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_hi[c] = 18'(p11_ff[8*c +: 8]) * 18'(ws3_ff)
                 + 18'(p01_ff[8*c +: 8]) * (18'd256 - 18'(ws3_ff));
         a_lo[c] = 18'(p10_ff[8*c +: 8]) * 18'(ws3_ff)
                 + 18'(p00_ff[8*c +: 8]) * (18'd256 - 18'(ws3_ff));
      end
   end
   logic       v4_ff, on4_ff, bil4_ff;
   logic [8:0] wt4_ff;
   logic [7:0] rhi4_ff [3], rlo4_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      on4_ff <= on3_ff; wt4_ff <= wt3_ff;
      bil4_ff <= (ws3_ff != 9'd256) && (wt3_ff != 9'd256);
      a_hi_ff <= a_hi; a_lo_ff <= a_lo;
      rhi4_ff <= rhi_ff; rlo4_ff <= rlo_ff;
   end

   logic [26:0] sum [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = 27'(a_hi_ff[c]) * 27'(wt4_ff)
                + 27'(a_lo_ff[c]) * (27'd256 - 27'(wt4_ff)) + 27'd32768;
         if (!on4_ff) res[c] = bts_pkg::GRAY_LEVEL;
         else if (bil4_ff) res[c] = sum[c][23:16];
         else res[c] = bts_pkg::lerp8(rhi4_ff[c], rlo4_ff[c], wt4_ff);
      end
      col_in = {res[2], res[1], res[0]};
   end

   // skid FIFO (depth 8 covers the pipeline)
   logic [23:0] fifo [0:7];
   logic [2:0]  wp_ff, rp_ff;
   logic [3:0]  occ_ff;
   always_ff @(posedge clock) begin
      if (v4_ff) fifo[wp_ff] <= col_in;
      if (reset) begin
         wp_ff <= 3'd0; rp_ff <= 3'd0; occ_ff <= 4'd0;
      end else begin
         if (v4_ff) wp_ff <= wp_ff + 3'd1;
         if (out_acc) rp_ff <= rp_ff + 3'd1;
         occ_ff <= occ_ff + 4'(v4_ff) - 4'(out_acc);
      end
   end

   // credit: items in flight plus queued must stay within the FIFO
   logic [3:0] inflight_ff;
   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= 4'd0;
      else inflight_ff <= inflight_ff + 4'(in_acc && req_tuser == bts_pkg::CMD_SAMPLE)
                          - 4'(out_acc);
   end
   assign req_tready = inflight_ff < 4'd8;
   assign rsp_tvalid = occ_ff != 4'd0;
   assign rsp_tdata  = {bts_pkg::ALPHA_ONE, fifo[rp_ff]};

   a_occ: assert property (@(posedge clock) disable iff (reset) occ_ff <= 4'd8)
      else $error("result queue overflow");
   a_cred: assert property (@(posedge clock) disable iff (reset) occ_ff <= inflight_ff)
      else $error("queue exceeds credits");
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 4'd0) |-> !rsp_tvalid)
      else $error("result without sample");

endmodule

`default_nettype wire

// ===== dv/tb_bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_texture_sampler
// Self-checking bench for the bilinear texture sampler.
// ----------------------------------------------------------------------------
// A queue of request words, filled phase by phase, feeds a driver; a monitor
// checks every response word against predicted pixels. Before each textured
// sample the bench loads every texel that the sample will read, so no such
// sample reads an unwritten texel. Phases sweep texture sizes, edge limits
// and the texture enable, with random idling on both sides and one long
// response hold-off that backs the pipeline up into the request side.
// ----------------------------------------------------------------------------
module tb_bilinear_texture_sampler;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 65;

   typedef struct {
      bit        cmd;
      bit [15:0] idx;
      bit [7:0]  red;
      bit [7:0]  green;
      bit [7:0]  blue;
      bit [17:0] s;
      bit [17:0] t;
   } req_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // predictor state
   bit [23:0]   texel_mem [int];
   int          tex_w = 256;
   int          tex_h = 256;
   int          s_limit = 65535;
   int          t_limit = 65535;
   bit          tex_on = 1'b0;
   int          row_pitch;
   int          touched[$];

   req_word_type req_words[$];
   bit [31:0]   expected_pixels[$];
   int          send_idle = 38;
   int          recv_idle = 67;
   bit          hold_req = 1'b0;
   int          hold_cnt = 0;
   bit          req_taken = 1'b0;
   int          mismatches = 0;
   int          cycles = 0;

   bilinear_texture_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int clamp_size(int v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Clamp Q2.16 to 0..1 and scale into Q8.8 texel units.
   function automatic int to_units(bit [17:0] raw, int size);
      int c;
      if (raw[17]) c = 0;
      else if (raw > 18'd65536) c = 65536;
      else c = int'(raw);
      return (c * (size - 1)) >> 8;
   endfunction

   function automatic bit [23:0] texel_at(int x, int y);
      int a;
      a = (x + y * row_pitch) & 32'hFFFF;
      touched.push_back(a);
      return texel_mem.exists(a) ? texel_mem[a] : 24'd0;
   endfunction

   function automatic bit [23:0] blend_texels(bit [17:0] s, bit [17:0] t);
      int x, y, u, v, fs, ft, ws, wt, sum;
      bit s_off, t_off;
      bit [23:0] p00, p01, p10, p11, rgb;
      row_pitch = clamp_size(tex_w, bts_pkg::MAX_TEX_WIDTH_DEF);
      x = to_units(s, row_pitch);
      y = to_units(t, clamp_size(tex_h, bts_pkg::MAX_TEX_HEIGHT_DEF));
      s_off = (x <= 128) || (x >= s_limit);
      t_off = (y <= 128) || (y >= t_limit);
      u = x + 128;
      v = y + 128;
      fs = u >> 8;
      ws = u & 255;
      ft = v >> 8;
      wt = v & 255;
      if (s_off && t_off) begin
         rgb = texel_at(u >> 8, v >> 8);
      end else if (s_off) begin
         p11 = texel_at(u >> 8, ft);
         p10 = texel_at(u >> 8, ft - 1);
         for (int c = 0; c < 3; c++)
            rgb[8*c +: 8] = (p11[8*c +: 8] * wt + p10[8*c +: 8] * (256 - wt) + 128) >> 8;
      end else if (t_off) begin
         p11 = texel_at(fs, v >> 8);
         p01 = texel_at(fs - 1, v >> 8);
         for (int c = 0; c < 3; c++)
            rgb[8*c +: 8] = (p11[8*c +: 8] * ws + p01[8*c +: 8] * (256 - ws) + 128) >> 8;
      end else begin
         p11 = texel_at(fs, ft);
         p10 = texel_at(fs, ft - 1);
         p01 = texel_at(fs - 1, ft);
         p00 = texel_at(fs - 1, ft - 1);
         for (int c = 0; c < 3; c++) begin
            sum = p11[8*c +: 8] * ws * wt + p10[8*c +: 8] * ws * (256 - wt)
                + p01[8*c +: 8] * (256 - ws) * wt
                + p00[8*c +: 8] * (256 - ws) * (256 - wt);
            rgb[8*c +: 8] = (sum + 32768) >> 16;
         end
      end
      return rgb;
   endfunction

   task automatic add_write(bit [15:0] idx, bit [23:0] color);
      req_word_type w;
      w.cmd = bts_pkg::CMD_WRITE;
      w.idx = idx;
      w.red = color[7:0];
      w.green = color[15:8];
      w.blue = color[23:16];
      w.s = 18'($urandom);
      w.t = 18'($urandom);
      texel_mem[idx] = color;
      req_words.push_back(w);
   endtask

   task automatic add_sample(bit [17:0] s, bit [17:0] t);
      req_word_type w;
      bit [23:0] rgb;
      bit [23:0] junk;
      if (tex_on) begin
         touched.delete();
         junk = blend_texels(s, t);
         // load whatever this sample reads that is still unwritten
         foreach (touched[i])
            if (!texel_mem.exists(touched[i]))
               add_write(16'(touched[i]), 24'($urandom));
         rgb = blend_texels(s, t);
      end else begin
         rgb = {bts_pkg::GRAY_LEVEL, bts_pkg::GRAY_LEVEL, bts_pkg::GRAY_LEVEL};
      end
      w.cmd = bts_pkg::CMD_SAMPLE;
      w.idx = 16'($urandom);
      w.red = 8'($urandom);
      w.green = 8'($urandom);
      w.blue = 8'($urandom);
      w.s = s;
      w.t = t;
      req_words.push_back(w);
      expected_pixels.push_back({bts_pkg::ALPHA_ONE, rgb});
   endtask

   function automatic bit [17:0] rand_coord();
      case ($urandom_range(4))
         0: return 18'($urandom);
         1: return 18'($urandom_range(600));
         2: return 18'(65536 - $urandom_range(600));
         default: return 18'($urandom_range(65536));
      endcase
   endfunction

   task automatic cfg_write(bit [2:0] idx, bit [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         bts_pkg::REG_TEX_WIDTH:  tex_w = int'(val & 16'h1FF);
         bts_pkg::REG_TEX_HEIGHT: tex_h = int'(val & 16'h1FF);
         bts_pkg::REG_S_EDGE:     s_limit = int'(val);
         bts_pkg::REG_T_EDGE:     t_limit = int'(val);
         bts_pkg::REG_TEX_ON:     tex_on = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (req_words.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      // writes leave no response; let the pipeline empty
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(int w, int h, int sl, int tl, bit on);
      cfg_write(bts_pkg::REG_TEX_WIDTH, 16'(w));
      cfg_write(bts_pkg::REG_TEX_HEIGHT, 16'(h));
      cfg_write(bts_pkg::REG_S_EDGE, 16'(sl));
      cfg_write(bts_pkg::REG_T_EDGE, 16'(tl));
      cfg_write(bts_pkg::REG_TEX_ON, 16'(on));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if ($urandom_range(99) < 25) add_write(16'($urandom), 24'($urandom));
         else add_sample(rand_coord(), rand_coord());
      end
   endtask

   // request driver
   always @(posedge clock) req_taken = req_tvalid && req_tready;

   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (req_taken) req_words.delete(0);
         if (req_words.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tuser <= req_words[0].cmd;
            req_tdata <= {4'b0, req_words[0].t, req_words[0].s, req_words[0].blue,
                          req_words[0].green, req_words[0].red, req_words[0].idx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_cnt = 400;
         hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // response checker
   always @(posedge clock) begin
      bit [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            want = expected_pixels.pop_front();
            for (int c = 0; c < 4; c++) begin
               if (rsp_tdata[8*c +: 8] !== want[8*c +: 8]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("channel %0d: expected %0d got %0d", c, want[8*c +: 8],
                              rsp_tdata[8*c +: 8]);
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: gray with no texture, then a 4x4 texture
      add_sample(18'h00000, 18'h00000);
      add_sample(18'h1FFFF, 18'h20000);
      drain();
      cfg_write(bts_pkg::REG_TEX_WIDTH, 16'd4);
      cfg_write(bts_pkg::REG_TEX_HEIGHT, 16'd4);
      cfg_write(bts_pkg::REG_TEX_ON, 16'd1);
      add_write(16'h0000, 24'h000000);
      add_write(16'hFFFF, 24'hFFFFFF);
      add_write(16'h0005, 24'hFFFFFF);
      add_sample(18'h00000, 18'h00000);
      add_sample(18'd65536, 18'd65536);
      add_sample(18'd32768, 18'd0);
      add_sample(18'd0, 18'd32768);
      add_sample(18'd32768, 18'd32768);
      add_sample(18'h3FFFF, 18'h1FFFF);
      add_sample(18'd65535, 18'd1);
      add_sample(18'd21845, 18'd43690);
      add_sample(18'h20000, 18'd65537);
      drain();
      cfg_write(3'd7, 16'hFFFF);  // unmapped register, no effect

      run_phase(4, 4, 65535, 65535, 1);
      drain();
      run_phase(1, 1, 65535, 65535, 1);
      drain();
      run_phase(256, 256, 65535, 65535, 1);
      hold_req = 1'b1;
      drain();
      send_idle = 67;
      recv_idle = 38;
      run_phase(0, 300, 0, 65535, 1);
      drain();
      run_phase(17, 9, $urandom_range(2048), $urandom_range(2048), 1);
      drain();
      run_phase(511, 2, 65535, 0, 1);
      drain();
      send_idle = 0;
      recv_idle = 0;
      run_phase(7, 200, 400, 300, 1);
      drain();
      run_phase(3, 5, 300, 300, 0);
      drain();
      run_phase(64, 33, 65535, 0, 1);
      drain();

      mismatches += expected_pixels.size();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
